// ===== design/tls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tls_pkg;

	// Event codes carried in s_axis_tuser.
	typedef logic [2:0] op_t;
	localparam op_t OP_TICK      = 3'd0;
	localparam op_t OP_MODE_EDGE = 3'd1;
	localparam op_t OP_WALK_EDGE = 3'd2;
	localparam op_t OP_SAMPLE    = 3'd3;
	localparam op_t OP_SET_RATE  = 3'd4;

	// Operating modes. Code 3 is unused and cannot be reached from reset.
	typedef logic [1:0] mode_t;
	localparam mode_t MODE_NORMAL       = 2'd0;
	localparam mode_t MODE_FLASH_YELLOW = 2'd1;
	localparam mode_t MODE_FLASH_RED    = 2'd2;

	// Lamp vector, green in the lowest bit.
	typedef logic [2:0] lamps_t;
	localparam lamps_t LAMP_G   = 3'b001;
	localparam lamps_t LAMP_Y   = 3'b010;
	localparam lamps_t LAMP_R   = 3'b100;
	localparam lamps_t LAMP_ALL = 3'b111;

	localparam logic [2:0] POS_YELLOW = 3'd3;
	localparam logic [2:0] POS_HOLD   = 3'd4;
	localparam logic [2:0] POS_SERVED = 3'd5;
	localparam logic [2:0] POS_LAST   = 3'd6;
	localparam logic [2:0] HOLD_TICKS = 3'd5;
	localparam logic [3:0] RATE_MIN   = 4'd1;
	localparam logic [3:0] RATE_MAX   = 4'd9;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;

	typedef struct packed {
		mode_t      mode;
		logic [2:0] pos;
		logic       walk_pending;
		logic [2:0] hold;
		logic       mode_btn_down;
		logic       walk_btn_down;
		logic       lamp_test;
		lamps_t     lamps;
		logic [3:0] rate;
	} state_t;

	localparam state_t STATE_RESET = '{
		mode:          MODE_NORMAL,
		pos:           3'd0,
		walk_pending:  1'b0,
		hold:          3'd0,
		mode_btn_down: 1'b0,
		walk_btn_down: 1'b0,
		lamp_test:     1'b0,
		lamps:         LAMP_G,
		rate:          RATE_MIN
	};

	typedef struct packed {
		logic       restart_period;
		logic       rate_rejected;
		logic       lamp_test_on;
		logic       walk_waiting;
		logic [3:0] rate_now;
		mode_t      mode_now;
		logic       red_lamp;
		logic       yellow_lamp;
		logic       green_lamp;
	} result_t;

endpackage

`default_nettype wire

// ===== design/tls_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Next-state and result logic for one event.
module tls_step
	import tls_pkg::*;
(
	input  wire state_t     cur,
	input  wire op_t        op,
	input  wire logic       mode_button_level,
	input  wire logic       walk_button_level,
	input  wire logic [7:0] rate_char,
	output state_t          nxt,
	output result_t         res
);

	logic [2:0] pos_inc;
	logic [2:0] hold_inc;
	logic [3:0] rate_diff;
	logic       rate_ok;
	logic       rejected;
	logic       restart;

	assign pos_inc   = (cur.pos < POS_LAST) ? 3'(cur.pos + 3'd1) : cur.pos;
	assign hold_inc  = 3'(cur.hold + 3'd1);
	assign rate_diff = 4'(rate_char - DIGIT_ZERO);
	assign rate_ok   = (rate_char >= (DIGIT_ZERO + 8'(RATE_MIN)))
		&& (rate_char <= (DIGIT_ZERO + 8'(RATE_MAX)));

	always_comb begin
		nxt      = cur;
		rejected = 1'b0;
		restart  = 1'b0;
		case (op)
			OP_TICK: begin
				restart = 1'b1;
				if (cur.lamp_test) begin
					nxt.lamps = LAMP_ALL;
				end else begin
					nxt.pos = pos_inc;
					case (cur.mode)
						MODE_NORMAL: begin
							if (pos_inc < POS_YELLOW) begin
								nxt.lamps = LAMP_G;
							end else if (pos_inc == POS_YELLOW) begin
								nxt.lamps = LAMP_Y;
							end else if (pos_inc < POS_LAST) begin
								if (cur.walk_pending) begin
									// Hold the crossing phase until the call is served.
									nxt.lamps = LAMP_Y | LAMP_R;
									nxt.pos   = POS_HOLD;
									nxt.hold  = hold_inc;
									if (hold_inc == HOLD_TICKS) begin
										nxt.walk_pending = 1'b0;
										nxt.hold         = 3'd0;
										nxt.pos          = POS_SERVED;
									end
								end else begin
									nxt.lamps = LAMP_R;
								end
							end else begin
								nxt.pos   = 3'd0;
								nxt.lamps = LAMP_G;
							end
						end
						MODE_FLASH_YELLOW: nxt.lamps = (cur.lamps & LAMP_Y) ^ LAMP_Y;
						MODE_FLASH_RED:    nxt.lamps = (cur.lamps & LAMP_R) ^ LAMP_R;
						default:           nxt.lamps = cur.lamps;
					endcase
				end
			end
			OP_MODE_EDGE: begin
				if (cur.mode_btn_down) begin
					nxt.mode_btn_down = 1'b0;
				end else begin
					nxt.mode_btn_down = 1'b1;
					nxt.walk_pending  = 1'b0;
					nxt.hold          = 3'd0;
					case (cur.mode)
						MODE_NORMAL:       nxt.mode = MODE_FLASH_YELLOW;
						MODE_FLASH_YELLOW: nxt.mode = MODE_FLASH_RED;
						default:           nxt.mode = MODE_NORMAL;
					endcase
				end
			end
			OP_WALK_EDGE: begin
				if (cur.walk_btn_down) begin
					nxt.walk_btn_down = 1'b0;
				end else begin
					nxt.walk_btn_down = 1'b1;
					nxt.walk_pending  = 1'b1;
				end
			end
			OP_SAMPLE: begin
				if (mode_button_level && walk_button_level) begin
					nxt.lamp_test = 1'b1;
					nxt.lamps     = LAMP_ALL;
				end else if (!mode_button_level && !walk_button_level) begin
					if (cur.lamp_test) begin
						nxt.lamp_test    = 1'b0;
						nxt.mode         = MODE_NORMAL;
						nxt.rate         = RATE_MIN;
						nxt.walk_pending = 1'b0;
						nxt.pos          = 3'd0;
						nxt.lamps        = LAMP_G;
						restart          = 1'b1;
					end
				end else begin
					nxt.lamp_test = 1'b0;
				end
			end
			OP_SET_RATE: begin
				if (rate_ok) begin
					nxt.rate = rate_diff;
					restart  = 1'b1;
				end else begin
					rejected = 1'b1;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	assign res.green_lamp     = nxt.lamps[0];
	assign res.yellow_lamp    = nxt.lamps[1];
	assign res.red_lamp       = nxt.lamps[2];
	assign res.mode_now       = nxt.mode;
	assign res.rate_now       = nxt.rate;
	assign res.walk_waiting   = nxt.walk_pending;
	assign res.lamp_test_on   = nxt.lamp_test;
	assign res.rate_rejected  = rejected;
	assign res.restart_period = restart;

endmodule

`default_nettype wire

// ===== design/traffic_light_sequencer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Traffic light sequencer core. Each request on the input stream is one event
// (period tick, mode button edge, walk button edge, settled button sample or a
// new rate digit) and produces exactly one result request on the output stream
// carrying the lamp states and status after that event. The block takes one
// event per cycle unless the output stalls: an event is captured in an input
// register, the next controller state and its result are formed by a single
// pass of logic, and the result lands in the output register as the event
// leaves the input register, then it is offered on the output stream. Output
// backpressure stalls the two registers in place, so no request is dropped or
// repeated. The host owns the period timer: it should restart it at rate_now
// whenever restart_period is set, and issue a tick when it expires. After reset
// the lamps show green, the mode is normal and the rate is 1 Hz.
module traffic_light_sequencer_core
	import tls_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// [0] mode_button_level, [1] walk_button_level, [9:2] rate_char, rest zero
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [2:0] op
	input  wire logic [2:0]            s_axis_tuser,

	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// [0] green_lamp, [1] yellow_lamp, [2] red_lamp, [4:3] mode_now,
	// [8:5] rate_now, [9] walk_waiting, [10] lamp_test_on,
	// [11] rate_rejected, [12] restart_period, rest zero
	output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

	// Input register stage.
	logic       valid_s1;
	op_t        op_s1;
	logic       mode_lvl_s1;
	logic       walk_lvl_s1;
	logic [7:0] rate_char_s1;

	// Result register stage.
	logic       valid_s2;
	result_t    res_s2;

	// Controller state, updated when the event in stage one moves on.
	state_t     state_q;
	state_t     state_nxt;
	result_t    res_nxt;

	logic       adv_s2;
	logic       adv_s1;

	// The result register can take a new value when it is empty or being read.
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s2;

	tls_step u_step (
		.cur               (state_q),
		.op                (op_s1),
		.mode_button_level (mode_lvl_s1),
		.walk_button_level (walk_lvl_s1),
		.rate_char         (rate_char_s1),
		.nxt               (state_nxt),
		.res               (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1        <= s_axis_tuser;
			mode_lvl_s1  <= s_axis_tdata[0];
			walk_lvl_s1  <= s_axis_tdata[1];
			rate_char_s1 <= s_axis_tdata[9:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, res_s2};

endmodule

`default_nettype wire

// ===== tb/traffic_light_sequencer_core_tb.sv =====
`timescale 1ns / 1ps

module traffic_light_sequencer_core_tb;
	import tls_pkg::*;

	localparam int STALL_CYCLES = 300;
	localparam int PHASE_EVENTS = 500;
	localparam int REPORT_LIMIT = 10;

	// Predicts the lamp and status word for every accepted event and checks the
	// output stream against it in order.
	class lamp_status_board;
		state_t ctrl;
		result_t expected_status[$];
		int errors;
		int results_seen;
		int ticks_seen;
		int lamp_tests_seen;
		int rates_rejected;

		function new();
			ctrl = STATE_RESET;
			errors = 0;
			results_seen = 0;
			ticks_seen = 0;
			lamp_tests_seen = 0;
			rates_rejected = 0;
		endfunction

		function int pending();
			return expected_status.size();
		endfunction

		function void advance_tick();
			if (ctrl.lamp_test) begin
				ctrl.lamps = LAMP_ALL;
				return;
			end
			if (ctrl.pos < POS_LAST)
				ctrl.pos = ctrl.pos + 3'd1;
			case (ctrl.mode)
			MODE_NORMAL: begin
				if (ctrl.pos < POS_YELLOW) begin
					ctrl.lamps = LAMP_G;
				end else if (ctrl.pos == POS_YELLOW) begin
					ctrl.lamps = LAMP_Y;
				end else if (ctrl.pos < POS_LAST) begin
					if (ctrl.walk_pending) begin
						// A pedestrian call parks the cycle on yellow and red until it is served.
						ctrl.lamps = LAMP_Y | LAMP_R;
						ctrl.pos = POS_HOLD;
						ctrl.hold = ctrl.hold + 3'd1;
						if (ctrl.hold == HOLD_TICKS) begin
							ctrl.walk_pending = 1'b0;
							ctrl.hold = 3'd0;
							ctrl.pos = POS_SERVED;
						end
					end else begin
						ctrl.lamps = LAMP_R;
					end
				end else begin
					ctrl.pos = 3'd0;
					ctrl.lamps = LAMP_G;
				end
			end
			MODE_FLASH_YELLOW: ctrl.lamps = (ctrl.lamps & LAMP_Y) ^ LAMP_Y;
			MODE_FLASH_RED:    ctrl.lamps = (ctrl.lamps & LAMP_R) ^ LAMP_R;
			default: ;
			endcase
		endfunction

		function void note_event(op_t op, logic mode_lvl, logic walk_lvl, logic [7:0] ch);
			result_t want;
			logic rejected;
			logic restart;
			rejected = 1'b0;
			restart = 1'b0;
			case (op)
			OP_TICK: begin
				advance_tick();
				restart = 1'b1;
				ticks_seen++;
			end
			OP_MODE_EDGE: begin
				if (ctrl.mode_btn_down) begin
					ctrl.mode_btn_down = 1'b0;
				end else begin
					ctrl.mode_btn_down = 1'b1;
					ctrl.walk_pending = 1'b0;
					ctrl.hold = 3'd0;
					case (ctrl.mode)
					MODE_NORMAL:       ctrl.mode = MODE_FLASH_YELLOW;
					MODE_FLASH_YELLOW: ctrl.mode = MODE_FLASH_RED;
					default:           ctrl.mode = MODE_NORMAL;
					endcase
				end
			end
			OP_WALK_EDGE: begin
				if (ctrl.walk_btn_down) begin
					ctrl.walk_btn_down = 1'b0;
				end else begin
					ctrl.walk_btn_down = 1'b1;
					ctrl.walk_pending = 1'b1;
				end
			end
			OP_SAMPLE: begin
				if (mode_lvl && walk_lvl) begin
					if (!ctrl.lamp_test)
						lamp_tests_seen++;
					ctrl.lamp_test = 1'b1;
					ctrl.lamps = LAMP_ALL;
				end else if (!mode_lvl && !walk_lvl) begin
					// Releasing both buttons ends a test; the hold count survives it.
					if (ctrl.lamp_test) begin
						ctrl.lamp_test = 1'b0;
						ctrl.mode = MODE_NORMAL;
						ctrl.rate = RATE_MIN;
						ctrl.walk_pending = 1'b0;
						ctrl.pos = 3'd0;
						ctrl.lamps = LAMP_G;
						restart = 1'b1;
					end
				end else begin
					ctrl.lamp_test = 1'b0;
				end
			end
			OP_SET_RATE: begin
				if (ch >= DIGIT_ZERO + RATE_MIN && ch <= DIGIT_ZERO + RATE_MAX) begin
					ctrl.rate = ch[3:0];
					restart = 1'b1;
				end else begin
					rejected = 1'b1;
					rates_rejected++;
				end
			end
			default: ;
			endcase
			want.green_lamp = ctrl.lamps[0];
			want.yellow_lamp = ctrl.lamps[1];
			want.red_lamp = ctrl.lamps[2];
			want.mode_now = ctrl.mode;
			want.rate_now = ctrl.rate;
			want.walk_waiting = ctrl.walk_pending;
			want.lamp_test_on = ctrl.lamp_test;
			want.rate_rejected = rejected;
			want.restart_period = restart;
			expected_status.push_back(want);
		endfunction

		function void compare_field(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("Mismatch in %s at %0t: expected %0d, got %0d",
						field, $realtime, want, got);
			end
		endfunction

		function void check_status(logic [OUT_DATA_W-1:0] data);
			result_t want;
			result_t got;
			got = data[$bits(result_t)-1:0];
			results_seen++;
			if (expected_status.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("Result %h at %0t arrived with nothing expected", data, $realtime);
				return;
			end
			want = expected_status.pop_front();
			compare_field("green_lamp", want.green_lamp, got.green_lamp);
			compare_field("yellow_lamp", want.yellow_lamp, got.yellow_lamp);
			compare_field("red_lamp", want.red_lamp, got.red_lamp);
			compare_field("mode_now", want.mode_now, got.mode_now);
			compare_field("rate_now", want.rate_now, got.rate_now);
			compare_field("walk_waiting", want.walk_waiting, got.walk_waiting);
			compare_field("lamp_test_on", want.lamp_test_on, got.lamp_test_on);
			compare_field("rate_rejected", want.rate_rejected, got.rate_rejected);
			compare_field("restart_period", want.restart_period, got.restart_period);
			compare_field("padding", 8'd0, data[OUT_DATA_W-1:$bits(result_t)]);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [2:0] s_axis_tuser = OP_TICK;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	lamp_status_board board = new();

	int send_idle_pct = 38;
	int recv_idle_pct = 46;
	int events_sent = 0;
	int stall_asks = 0;

	always #4 clk = ~clk;

	traffic_light_sequencer_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Both handshakes are observed at the rising edge; requests are noted first.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			board.note_event(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[1],
				s_axis_tdata[9:2]);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_status(m_axis_tdata);
	end

	// Output side: random backpressure, plus a long hold whenever one is asked for.
	always @(negedge clk) begin : result_sink
		int stall_left;
		int stall_done;
		if (stall_asks != stall_done) begin
			stall_done = stall_asks;
			stall_left = STALL_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic send_event(op_t op, logic mode_lvl, logic walk_lvl, logic [7:0] ch);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {6'd0, ch, walk_lvl, mode_lvl};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (op <= OP_SET_RATE)
			events_sent++;
	endtask

	// Unused fields of each request carry random bits.
	task automatic send_op(op_t op);
		send_event(op, 1'($urandom), 1'($urandom), 8'($urandom));
	endtask

	task automatic send_rate(logic [7:0] ch);
		send_event(OP_SET_RATE, 1'($urandom), 1'($urandom), ch);
	endtask

	task automatic send_sample(logic mode_lvl, logic walk_lvl);
		send_event(OP_SAMPLE, mode_lvl, walk_lvl, 8'($urandom));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic directed_events();
		// A pedestrian call, then a full normal cycle that holds and serves it.
		send_op(OP_WALK_EDGE);
		send_op(OP_WALK_EDGE);
		repeat (9) send_op(OP_TICK);
		send_op(OP_TICK);
		// The top rate digit, characters just outside the digit range and 8'hff.
		send_rate(DIGIT_ZERO + 8'(RATE_MAX));
		send_rate(DIGIT_ZERO);
		send_rate(8'hff);
		send_rate(DIGIT_ZERO + 8'd10);
		// Walk through both flashing modes and back to normal.
		send_op(OP_MODE_EDGE);
		send_op(OP_TICK);
		send_op(OP_MODE_EDGE);
		send_op(OP_MODE_EDGE);
		send_op(OP_TICK);
		send_op(OP_MODE_EDGE);
		send_op(OP_MODE_EDGE);
		// Lamp test: start, a tick inside it, the end, then a test cut short.
		send_sample(1'b1, 1'b1);
		send_op(OP_TICK);
		send_sample(1'b0, 1'b0);
		send_sample(1'b1, 1'b1);
		send_sample(1'b0, 1'b1);
		send_op(3'd7);
	endtask

	// One burst is mostly a well-formed sequence with random content, sometimes noise.
	task automatic random_burst();
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			repeat ($urandom_range(1, 8)) send_op(OP_TICK);
		end else if (kind < 48) begin
			send_op(OP_WALK_EDGE);
			if ($urandom_range(0, 9) < 8)
				send_op(OP_WALK_EDGE);
			repeat ($urandom_range(4, 12)) send_op(OP_TICK);
		end else if (kind < 60) begin
			send_op(OP_MODE_EDGE);
			if ($urandom_range(0, 9) < 9)
				send_op(OP_MODE_EDGE);
			repeat ($urandom_range(1, 6)) send_op(OP_TICK);
		end else if (kind < 70) begin
			send_sample(1'b1, 1'b1);
			repeat ($urandom_range(0, 3)) send_op(OP_TICK);
			if ($urandom_range(0, 9) < 7)
				send_sample(1'b0, 1'b0);
			else if ($urandom_range(0, 1) == 0)
				send_sample(1'b1, 1'b0);
			else
				send_sample(1'b0, 1'b1);
		end else if (kind < 82) begin
			if ($urandom_range(0, 9) < 7)
				send_rate(DIGIT_ZERO + 8'($urandom_range(RATE_MIN, RATE_MAX)));
			else
				send_rate(8'($urandom));
		end else if (kind < 90) begin
			send_sample(1'($urandom), 1'($urandom));
		end else begin
			send_op(3'($urandom));
		end
	endtask

	task automatic random_phase(int send_pct, int recv_pct, int count);
		int start;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start = events_sent;
		while (events_sent - start < count)
			random_burst();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_events();

		// Sender and receiver both idle; halfway through the receiver stops for a
		// long stretch so the pipeline fills and the input stalls.
		random_phase(38, 46, PHASE_EVENTS / 2);
		stall_asks++;
		random_phase(38, 46, PHASE_EVENTS / 2);
		wait_drained();

		// Roles swapped, with a pause in the middle until everything has come back.
		random_phase(46, 38, PHASE_EVENTS / 2);
		wait_drained();
		random_phase(46, 38, PHASE_EVENTS / 2);
		wait_drained();

		random_phase(0, 0, PHASE_EVENTS);
		wait_drained();
		repeat (10) @(posedge clk);

		$display("Covered %0d events: %0d ticks, %0d lamp tests, %0d rejected rate digits.",
			events_sent, board.ticks_seen, board.lamp_tests_seen, board.rates_rejected);
		$display("Checked %0d results, %0d mismatches.", board.results_seen, board.errors);
		if (board.errors == 0 && board.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d results still outstanding.", board.pending());
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== traffic_light_sequencer_core.f =====
design/tls_pkg.sv
design/tls_step.sv
design/traffic_light_sequencer_core.sv
tb/traffic_light_sequencer_core_tb.sv
